### rtl/joystick_switch_report_packer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the joystick switch report packer
// Concurrent checks clocked by clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_SWITCH_REPORT_PACKER_DEFINES_SVH
`define JOYSTICK_SWITCH_REPORT_PACKER_DEFINES_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define JSRP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("joystick switch report packer check failed");

// When the antecedent holds, the consequent must hold in the following cycle.
`define JSRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("joystick switch report packer next-cycle check failed");

`else

`define JSRP_ASSERT(lbl, prop)
`define JSRP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/jsrp_pkg.sv
// ----------------------------------------------------------------------------
// jsrp_pkg
// Shared widths, reset values, register indexes and the ADC scaling function.
// ----------------------------------------------------------------------------
package jsrp_pkg;

  localparam int AdcW      = 10;
  localparam int SwitchW   = 4;
  localparam int TimeW     = 32;
  localparam int CfgDataW  = 16;
  localparam int CfgIdxW   = 2;
  localparam int ByteW     = 8;
  localparam int NibbleW   = 4;
  localparam int WordW     = 32;
  localparam int NumSwitches = 4;

  localparam logic [AdcW-1:0] AdcMax = 10'd1023;
  localparam logic [7:0] StickScale = 8'd255;
  localparam logic [7:0] PanScale   = 8'd15;

  localparam logic [7:0]  DeadbandRst = 8'd5;
  localparam logic [15:0] DebounceRst = 16'd50;
  localparam logic [9:0]  LowBattRst  = 10'd706;
  localparam logic [15:0] BlinkRst    = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEADBAND = 2'd0,
    CFG_DEBOUNCE = 2'd1,
    CFG_LOW_BATT = 2'd2,
    CFG_BLINK    = 2'd3
  } cfg_idx_e;

  // v*m/1023 with truncation. Writing p = q0*1024 + lo gives p = q0*1023 + (lo + q0),
  // and lo + q0 stays below 2*1023, so one compare corrects the estimate.
  function automatic logic [7:0] scale_adc(input logic [AdcW-1:0] v, input logic [7:0] m);
    logic [17:0] p;
    logic [7:0]  q0;
    logic [10:0] r;
    p  = 18'(v) * 18'(m);
    q0 = p[17:10];
    r  = 11'(p[9:0]) + 11'(q0);
    scale_adc = q0 + 8'(r >= 11'(AdcMax));
  endfunction

endpackage

### rtl/jsrp_debounce.sv
// ----------------------------------------------------------------------------
// jsrp_debounce
// Per-switch debouncers: a level is taken once it has held for the hold time.
// ----------------------------------------------------------------------------
module jsrp_debounce #(
  parameter int NUM_SWITCHES = jsrp_pkg::NumSwitches
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [jsrp_pkg::SwitchW-1:0]  levels_i,
  input  logic [jsrp_pkg::TimeW-1:0]    now_i,
  input  logic [15:0]                   hold_ms_i,
  output logic [NUM_SWITCHES-1:0]       stable_d_o
);
  import jsrp_pkg::*;

  logic [NUM_SWITCHES-1:0] seen_q;
  logic [NUM_SWITCHES-1:0] stable_q;
  logic [TimeW-1:0]        tchg_q [NUM_SWITCHES];
  logic [TimeW-1:0]        tchg_d [NUM_SWITCHES];
  logic [NUM_SWITCHES-1:0] lvl;
  logic [7:0]              lvl_ext;

  // Switches beyond the input width read as level zero.
  assign lvl_ext = 8'(levels_i);
  assign lvl     = lvl_ext[NUM_SWITCHES-1:0];

  always_comb begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      tchg_d[i] = (seen_q[i] != lvl[i]) ? now_i : tchg_q[i];
      stable_d_o[i] = ((now_i - tchg_d[i]) >= TimeW'(hold_ms_i)) ? lvl[i] : stable_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      stable_q <= '0;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        tchg_q[i] <= '0;
      end
    end else if (en_i) begin
      seen_q   <= lvl;
      stable_q <= stable_d_o;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        tchg_q[i] <= tchg_d[i];
      end
    end
  end

endmodule

### rtl/joystick_switch_report_packer.sv
// ----------------------------------------------------------------------------
// joystick_switch_report_packer
// Flow: an accepted word is captured in the input register, which hands it to
// the result register unless the output is stalled; the result register then
// offers it on the output. Throughput: one word per cycle while the output is
// not stalled, set by the single compute stage between those two registers.
// Reset: asynchronous, active low; clears the valid flags of both stages, all
// tracking state and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
`include "joystick_switch_report_packer_defines.svh"

module joystick_switch_report_packer #(
  parameter int NUM_SWITCHES = jsrp_pkg::NumSwitches
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jsrp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [jsrp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [jsrp_pkg::AdcW-1:0]      stick_x_raw_i,
  input  logic [jsrp_pkg::AdcW-1:0]      stick_y_raw_i,
  input  logic [jsrp_pkg::AdcW-1:0]      pan_raw_i,
  input  logic [jsrp_pkg::AdcW-1:0]      tilt_raw_i,
  input  logic [jsrp_pkg::SwitchW-1:0]   switch_levels_i,
  input  logic [jsrp_pkg::AdcW-1:0]      battery_raw_i,
  input  logic [jsrp_pkg::TimeW-1:0]     now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           send_report_o,
  output logic [jsrp_pkg::WordW-1:0]     report_word_o,
  output logic                           led_on_o
);
  import jsrp_pkg::*;

  // Configuration registers.
  logic [7:0]  deadband_q;
  logic [15:0] debounce_q;
  logic [9:0]  low_batt_q;
  logic [15:0] blink_q;

  // Input register stage.
  logic             in_valid_q;
  logic [AdcW-1:0]  x_raw_q, y_raw_q, pan_raw_q, tilt_raw_q, batt_q;
  logic [SwitchW-1:0] sw_q;
  logic [TimeW-1:0] now_q;

  // Tracking state.
  logic [ByteW-1:0]        sent_x_q, sent_y_q, sent_pt_q;
  logic [NUM_SWITCHES-1:0] sent_sw_q;
  logic                    led_level_q, led_level_d;
  logic [TimeW-1:0]        led_time_q;
  logic                    led_toggle;

  // Result register.
  logic             out_valid_q;
  logic             send_q;
  logic [WordW-1:0] word_q;
  logic             led_q;

  logic                    advance;
  logic [ByteW-1:0]        x, y, pan8, tilt8, pt;
  logic [ByteW-1:0]        dx, dy;
  logic [NUM_SWITCHES-1:0] stable_d;
  logic                    send;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DeadbandRst;
      debounce_q <= DebounceRst;
      low_batt_q <= LowBattRst;
      blink_q    <= BlinkRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEADBAND: deadband_q <= cfg_data_i[7:0];
        CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_LOW_BATT: low_batt_q <= cfg_data_i[9:0];
        CFG_BLINK:    blink_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_raw_q    <= stick_x_raw_i;
      y_raw_q    <= stick_y_raw_i;
      pan_raw_q  <= pan_raw_i;
      tilt_raw_q <= tilt_raw_i;
      sw_q       <= switch_levels_i;
      batt_q     <= battery_raw_i;
      now_q      <= now_ms_i;
    end
  end

  // Low-battery blinker.
  assign led_toggle  = (batt_q <= low_batt_q) &&
                       ((now_q - led_time_q) >= TimeW'(blink_q));
  assign led_level_d = led_level_q ^ led_toggle;

  assign x     = scale_adc(x_raw_q, StickScale);
  assign y     = scale_adc(y_raw_q, StickScale);
  assign pan8  = scale_adc(pan_raw_q, PanScale);
  assign tilt8 = scale_adc(tilt_raw_q, PanScale);
  assign pt    = {tilt8[NibbleW-1:0], pan8[NibbleW-1:0]};

  jsrp_debounce #(
    .NUM_SWITCHES(NUM_SWITCHES)
  ) u_debounce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .levels_i   (sw_q),
    .now_i      (now_q),
    .hold_ms_i  (debounce_q),
    .stable_d_o (stable_d)
  );

  assign dx   = (x > sent_x_q) ? (x - sent_x_q) : (sent_x_q - x);
  assign dy   = (y > sent_y_q) ? (y - sent_y_q) : (sent_y_q - y);
  assign send = (dx > deadband_q) || (dy > deadband_q) ||
                (pt != sent_pt_q) || (stable_d != sent_sw_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_x_q    <= '0;
      sent_y_q    <= '0;
      sent_pt_q   <= '0;
      sent_sw_q   <= '0;
      led_level_q <= 1'b0;
      led_time_q  <= '0;
    end else if (advance) begin
      led_level_q <= led_level_d;
      if (led_toggle) begin
        led_time_q <= now_q;
      end
      if (send) begin
        sent_x_q  <= x;
        sent_y_q  <= y;
        sent_pt_q <= pt;
        sent_sw_q <= stable_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      send_q <= send;
      word_q <= {ByteW'(stable_d), pt, x, y};
      led_q  <= led_level_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign send_report_o = send_q;
  assign report_word_o = word_q;
  assign led_on_o      = led_q;

  // The input side stalls only when both stages hold a word and the output is blocked.
  `JSRP_ASSERT(a_stall_cause, !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
  // A flagged report on the output matches the last-sent values it just loaded.
  `JSRP_ASSERT(a_sent_match, (out_valid_q && send_q) |->
               (sent_y_q == word_q[7:0] && sent_x_q == word_q[15:8] &&
                sent_pt_q == word_q[23:16]))
  // The LED level reported on the output is the current blinker state.
  `JSRP_ASSERT(a_led_match, out_valid_q |-> (led_q == led_level_q))
  // Tracking state moves only when a word passes through the compute stage.
  `JSRP_ASSERT_NEXT(a_state_hold, !advance,
                    $stable(led_level_q) && $stable(led_time_q) &&
                    $stable(sent_sw_q) && $stable(sent_pt_q))

endmodule
